// ----- src/motmf_pkg.sv -----
// shared types and constants for the median-of-three mean filter
`timescale 1ns / 1ps

package motmf_pkg;

   // fixed field widths
   localparam int COUNT_W  = 8;
   localparam int AVG_W    = 16;
   localparam int SAMPLE_W = 16;

   // sample positions within a group of three
   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_THIRD  = 2'd2;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_DIV_LOAD,
      ST_DIVIDE,
      ST_PUBLISH
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic accept;
      logic accumulate;
      logic div_load;
      logic div_step;
      logic publish;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic pos_third;
      logic emit_due;
      logic div_last;
   } stat_type;

endpackage

// ----- src/motmf_ctrl.sv -----
// controller state machine for the median-of-three mean filter
`timescale 1ns / 1ps

module motmf_ctrl
   import motmf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // output register can take a new beat
   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && stat.pos_third) state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            state_in = stat.emit_due ? ST_DIV_LOAD : ST_IDLE;
         end
         ST_DIV_LOAD: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (stat.div_last) state_in = ST_PUBLISH;
         end
         ST_PUBLISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // commands and handshake outputs
   always_comb begin
      cmd          = '0;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_ACCUM: begin
            cmd.accumulate = 1'b1;
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_PUBLISH: begin
            cmd.publish = out_free;
            if (out_free) rsp_valid_in = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

   // state and result valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- src/motmf_dp.sv -----
// datapath: sample hold, median, accumulator, serial divider and result register
`timescale 1ns / 1ps

module motmf_dp
   import motmf_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [SAMPLE_W-1:0] req_tdata,
   output logic [AVG_W-1:0]    rsp_tdata,
   input  logic                csr_wr_en,
   input  logic [COUNT_W-1:0]  csr_wr_data,
   input  cmd_type             cmd,
   output stat_type            stat
);

   localparam int SUM_W = SAMPLE_BITS + COUNT_W;
   localparam int CNT_W = $clog2(SAMPLE_BITS);

   logic [COUNT_W-1:0]     count_ff;
   logic [1:0]             pos_ff;
   logic [SAMPLE_BITS-1:0] first_ff, second_ff, median_ff;
   logic [SAMPLE_BITS-1:0] sample_m, median_in, lo, hi;
   logic [SUM_W-1:0]       sum_ff;
   logic [COUNT_W-1:0]     taken_ff, taken_next, target;
   logic [COUNT_W-1:0]     rem_ff, divisor_ff, rem_in;
   logic [SAMPLE_BITS-1:0] quo_ff;
   logic [COUNT_W:0]       trial;
   logic                   fits;
   logic [CNT_W-1:0]       step_ff;
   logic [AVG_W-1:0]       average_ff;

   // unused high sample bits dropped
   assign sample_m = req_tdata[SAMPLE_BITS-1:0];

   // median of the held pair and the incoming sample
   always_comb begin
      lo = (first_ff > second_ff) ? second_ff : first_ff;
      hi = (first_ff > second_ff) ? first_ff : second_ff;
      if (sample_m > hi) begin
         median_in = hi;
      end else if (sample_m > lo) begin
         median_in = sample_m;
      end else begin
         median_in = lo;
      end
   end

   // mean due once the count is reached, zero count acts as one
   assign taken_next = taken_ff + COUNT_W'(1);
   assign target     = (count_ff == '0) ? COUNT_W'(1) : count_ff;

   // one restoring division step
   assign trial  = {rem_ff, quo_ff[SAMPLE_BITS-1]};
   assign fits   = trial >= {1'b0, divisor_ff};
   assign rem_in = fits ? COUNT_W'(trial - {1'b0, divisor_ff}) : trial[COUNT_W-1:0];

   assign stat.pos_third = (pos_ff == POS_THIRD);
   assign stat.emit_due  = (taken_next != '0) && (taken_next >= target);
   assign stat.div_last  = (step_ff == CNT_W'(SAMPLE_BITS - 1));

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_W'(1);
         pos_ff   <= POS_FIRST;
         sum_ff   <= '0;
         taken_ff <= '0;
         step_ff  <= '0;
      end else begin
         if (csr_wr_en) count_ff <= csr_wr_data;
         if (cmd.accept) begin
            case (pos_ff)
               POS_FIRST:  pos_ff <= POS_SECOND;
               POS_SECOND: pos_ff <= POS_THIRD;
               default:    pos_ff <= POS_FIRST;
            endcase
         end
         if (cmd.accumulate) begin
            sum_ff   <= sum_ff + SUM_W'(median_ff);
            taken_ff <= taken_next;
         end
         if (cmd.div_load) begin
            sum_ff   <= '0;
            taken_ff <= '0;
            step_ff  <= '0;
         end
         if (cmd.div_step) step_ff <= step_ff + CNT_W'(1);
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         case (pos_ff)
            POS_FIRST:  first_ff  <= sample_m;
            POS_SECOND: second_ff <= sample_m;
            default:    median_ff <= median_in;
         endcase
      end
      // high bits of the sum stay below the count, so they seed the remainder
      if (cmd.div_load) begin
         rem_ff     <= sum_ff[SUM_W-1:SAMPLE_BITS];
         quo_ff     <= sum_ff[SAMPLE_BITS-1:0];
         divisor_ff <= taken_ff;
      end
      if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[SAMPLE_BITS-2:0], fits};
      end
      if (cmd.publish) average_ff <= AVG_W'(quo_ff);
   end

   assign rsp_tdata = average_ff;

endmodule

// ----- src/median_of_three_mean_filter.sv -----
// top level of the median-of-three mean filter
//
//  channel   direction  beat contents
//  req_      in         tdata[15:0] sample
//  rsp_      out        tdata[15:0] average
//  csr_      in         wr_data[7:0] median_count, written when wr_en is high
//
// a sample that does not close a group is taken in the idle state; the third
// sample of a group is taken and then accumulated. a mean adds a load step, the
// one-bit-per-cycle restoring divider and a publish step.
// reset clears the group, the sum and the result valid and sets the count to 1.
// while a result waits for rsp_tready, samples are still taken until the next
// mean is ready to publish; the block then holds until the waiting beat leaves.
`timescale 1ns / 1ps

module median_of_three_mean_filter
   import motmf_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [SAMPLE_W-1:0] req_tdata,   // [15:0] sample
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [AVG_W-1:0]    rsp_tdata,   // [15:0] average
   input  logic                csr_wr_en,
   input  logic [COUNT_W-1:0]  csr_wr_data  // [7:0] median_count
);

   cmd_type  cmd;
   stat_type stat;

   // sequencing
   motmf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // arithmetic and storage
   motmf_dp #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule
